// ===== hdl/llde_pkg.sv =====
// Package: shared types and constants for the light level debounce event framer.
`default_nettype none
package llde_pkg;

   localparam int TimeWidth  = 32;
   localparam int LimitWidth = 16;
   localparam int CountWidth = 16;
   localparam int FrameLen   = 10;
   localparam int IdxWidth   = $clog2(FrameLen);
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 16;
   localparam int QueueDepth = 2;
   localparam int QPtrWidth  = $clog2(QueueDepth);

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE_MS = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DEVICE_CODE = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PORT_NUMBER = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_ENTER_CODE  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_LEAVE_CODE  = 3'd4;

   // register reset values
   localparam logic [LimitWidth-1:0] RST_DEBOUNCE_MS = 16'd200;
   localparam logic [7:0] RST_DEVICE_CODE = 8'd12;
   localparam logic [7:0] RST_PORT_NUMBER = 8'd0;
   localparam logic [7:0] RST_ENTER_CODE  = 8'd0;
   localparam logic [7:0] RST_LEAVE_CODE  = 8'd1;

   // frame bytes
   localparam logic [7:0] FRAME_START   = 8'hF0;
   localparam logic [7:0] FRAME_VERSION = 8'h01;
   localparam logic [7:0] FRAME_KIND    = 8'h04;
   localparam logic [7:0] FRAME_STOP    = 8'hFF;
   localparam logic [7:0] STATE_BYTE_LIT   = 8'h01;
   localparam logic [7:0] STATE_BYTE_UNLIT = 8'h02;

   // byte positions within a frame
   localparam logic [IdxWidth-1:0] POS_START   = 4'd0;
   localparam logic [IdxWidth-1:0] POS_VERSION = 4'd1;
   localparam logic [IdxWidth-1:0] POS_DEVICE  = 4'd2;
   localparam logic [IdxWidth-1:0] POS_PORT    = 4'd3;
   localparam logic [IdxWidth-1:0] POS_KIND    = 4'd4;
   localparam logic [IdxWidth-1:0] POS_STATE   = 4'd5;
   localparam logic [IdxWidth-1:0] POS_CODE    = 4'd6;
   localparam logic [IdxWidth-1:0] POS_CNT_LO  = 4'd7;
   localparam logic [IdxWidth-1:0] POS_CNT_HI  = 4'd8;
   localparam logic [IdxWidth-1:0] POS_STOP    = 4'd9;

   typedef enum logic [1:0] {
      MODE_BRIGHT   = 2'd1,
      MODE_DARK     = 2'd2,
      MODE_DEBOUNCE = 2'd3
   } mode_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 level;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_type;

   // one pending frame, handed from front to back
   typedef struct packed {
      logic                  is_dark;
      logic [7:0]            code;
      logic [CountWidth-1:0] count;
   } evt_type;

   // frame fields the user keeps fixed while items are in flight; the block does not enforce it
   typedef struct packed {
      logic [7:0] device_code;
      logic [7:0] port_number;
   } hdr_type;

endpackage
`default_nettype wire

// ===== hdl/llde_front.sv =====
// Front: accepts polls, runs the debounce mode machine and issues frame events.
`default_nettype none
module llde_front
   import llde_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire req_type               req_data,
   input  wire logic [LimitWidth-1:0] debounce_ms,
   input  wire logic [7:0]            enter_code,
   input  wire logic [7:0]            leave_code,
   output      logic                  evt_push,
   output      evt_type               evt_data
);

   mode_type              mode_ff, mode_in;
   logic                  last_level_ff, last_level_in;
   logic [TimeWidth-1:0]  start_ff, start_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [TimeWidth-1:0]  elapsed;

   assign elapsed = req_data.now_ms - start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BRIGHT;
         last_level_ff <= 1'b1;
         start_ff      <= '0;
         count_ff      <= '0;
      end else begin
         mode_ff       <= mode_in;
         last_level_ff <= last_level_in;
         start_ff      <= start_in;
         count_ff      <= count_in;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      last_level_in = last_level_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      evt_push      = 1'b0;
      evt_data.is_dark = ~req_data.level;
      evt_data.code    = req_data.level ? leave_code : enter_code;
      evt_data.count   = req_data.level ? count_ff : count_ff + 1'b1;
      case (mode_ff)
         MODE_DEBOUNCE: begin
            // level is ignored until the lockout has run out
            if (accept && (elapsed > {{(TimeWidth-LimitWidth){1'b0}}, debounce_ms})) begin
               mode_in = last_level_ff ? MODE_BRIGHT : MODE_DARK;
            end
         end
         default: begin
            if (accept && (req_data.level != last_level_ff)) begin
               mode_in       = MODE_DEBOUNCE;
               last_level_in = req_data.level;
               start_in      = req_data.now_ms;
               count_in      = evt_data.count;
               evt_push      = 1'b1;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/llde_queue.sv =====
// Queue: short FIFO of pending frame events between front and back.
`default_nettype none
module llde_queue
   import llde_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire evt_type push_data,
   input  wire logic    pop,
   output      logic    full,
   output      logic    not_empty,
   output      evt_type head
);

   evt_type                entry_ff [QueueDepth];
   logic [QPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPtrWidth:0]     fill_ff, fill_in;

   assign full      = (fill_ff == (QPtrWidth+1)'(QueueDepth));
   assign not_empty = (fill_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPtrWidth+1)'(push) - (QPtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/llde_back.sv =====
// Back: serializes each queued event into ten frame bytes on the result channel.
`default_nettype none
module llde_back
   import llde_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    evt_valid,
   input  wire evt_type evt_data,
   input  wire hdr_type hdr,
   output      logic    evt_pop,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   rsp_type             data_ff, data_in;
   logic                load;
   logic [7:0]          byte_sel;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // output register takes a new byte when empty or being drained
   assign load    = evt_valid && (!valid_ff || rsp_ready);
   assign evt_pop = load && (idx_ff == POS_STOP);

   always_comb begin
      case (idx_ff)
         POS_START:   byte_sel = FRAME_START;
         POS_VERSION: byte_sel = FRAME_VERSION;
         POS_DEVICE:  byte_sel = hdr.device_code;
         POS_PORT:    byte_sel = hdr.port_number;
         POS_KIND:    byte_sel = FRAME_KIND;
         POS_STATE:   byte_sel = evt_data.is_dark ? STATE_BYTE_UNLIT : STATE_BYTE_LIT;
         POS_CODE:    byte_sel = evt_data.code;
         POS_CNT_LO:  byte_sel = evt_data.count[7:0];
         POS_CNT_HI:  byte_sel = evt_data.count[15:8];
         POS_STOP:    byte_sel = FRAME_STOP;
         default:     byte_sel = FRAME_STOP;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in           = 1'b1;
         data_in.frame_byte = byte_sel;
         data_in.frame_end  = (idx_ff == POS_STOP);
         idx_in             = (idx_ff == POS_STOP) ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

// ===== hdl/light_level_debounce_event_framer.sv =====
// A poll that starts a frame writes its event into the queue; the back end loads its bytes into the output register.
// Throughput: one poll per cycle while the two-entry event queue has room; the back end drives
//   one byte per cycle while rsp_ready is high, ten per event, so queue drain sets any input stall.
// Reset (synchronous, active high): mode bright, last level bright, counters and queue
//   cleared, registers to their defaults; no clearing pass, ready as soon as reset drops.
`default_nettype none
module light_level_debounce_event_framer
   import llde_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // poll channel
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire req_type                 req_data,
   // frame byte channel
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      rsp_type                 rsp_data,
   // register writes
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   logic [LimitWidth-1:0] debounce_ms_ff;
   logic [7:0]            device_code_ff;
   logic [7:0]            port_number_ff;
   logic [7:0]            enter_code_ff;
   logic [7:0]            leave_code_ff;

   logic    accept;
   logic    evt_push;
   evt_type evt_push_data;
   logic    evt_pop;
   logic    q_full;
   logic    q_not_empty;
   evt_type q_head;
   hdr_type hdr;

   // Register file: take a write whenever enabled; drop unknown indexes and high bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= RST_DEBOUNCE_MS;
         device_code_ff <= RST_DEVICE_CODE;
         port_number_ff <= RST_PORT_NUMBER;
         enter_code_ff  <= RST_ENTER_CODE;
         leave_code_ff  <= RST_LEAVE_CODE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_MS: debounce_ms_ff <= csr_wdata;
            CSR_DEVICE_CODE: device_code_ff <= csr_wdata[7:0];
            CSR_PORT_NUMBER: port_number_ff <= csr_wdata[7:0];
            CSR_ENTER_CODE:  enter_code_ff  <= csr_wdata[7:0];
            CSR_LEAVE_CODE:  leave_code_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Hold off polls only while the queue could not take a new event.
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Header bytes are read live: the user changes registers only while nothing is in flight; not enforced.
   assign hdr.device_code = device_code_ff;
   assign hdr.port_number = port_number_ff;

   // Front: classify each poll, advance the debounce mode, issue events.
   llde_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .debounce_ms (debounce_ms_ff),
      .enter_code  (enter_code_ff),
      .leave_code  (leave_code_ff),
      .evt_push    (evt_push),
      .evt_data    (evt_push_data)
   );

   // Queue: decouple polling from frame emission.
   llde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt_push_data),
      .pop       (evt_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // Back: stream the ten bytes of each event through the output register.
   llde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (q_not_empty),
      .evt_data  (q_head),
      .hdr       (hdr),
      .evt_pop   (evt_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the light level debounce event framer.
`timescale 1ns / 1ps
module testbench;
   import llde_pkg::*;

   // Generous watchdog bound on the length of the run.
   localparam int CycleLimit   = 1_000_000;
   // Margin after the last byte before touching registers or ending; the
   // front end settles at the accepting edge, so this is slack only.
   localparam int SettleCycles = 6;
   // Indexes above the last defined register must be ignored by the block.
   localparam logic [CsrIdxWidth-1:0] CSR_FIRST_UNUSED = CSR_LEAVE_CODE + 1'b1;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_type                 rsp_data;
   logic                    csr_we;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   light_level_debounce_event_framer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Shadow of the block: register copies and sensor state
   // ------------------------------------------------------------------
   logic [LimitWidth-1:0] cfg_lockout_ms;
   logic [7:0]            cfg_device;
   logic [7:0]            cfg_port;
   logic [7:0]            cfg_enter;
   logic [7:0]            cfg_leave;

   mode_type              lamp_mode;
   logic                  seen_level;
   logic [TimeWidth-1:0]  lockout_start;
   logic [CountWidth-1:0] dark_entries;

   // frame bytes still owed by the block, oldest first
   rsp_type frames_due[$];

   logic [TimeWidth-1:0] poll_ms;
   bit  idle_on;
   int  polls_sent;
   int  bytes_checked;
   int  frames_checked;
   int  mismatch_count;
   int  random_phases;
   longint cycle_count;

   // ------------------------------------------------------------------
   // Clock and watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t: watchdog expired with %0d frame bytes outstanding",
                  $time, frames_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor: advance the shadow state by one poll, queue the frame it
   // causes. Return 1 when the poll did something (left the lockout or
   // started a frame); polls swallowed by the lockout or repeating the level return 0.
   // ------------------------------------------------------------------
   function automatic bit track_poll(req_type poll);
      logic [TimeWidth-1:0] elapsed;
      logic [7:0]           state_byte;
      logic [7:0]           code_byte;
      logic [7:0]           frame_bytes [FrameLen];
      rsp_type              entry;
      if (lamp_mode == MODE_DEBOUNCE) begin
         // the exit poll never looks at the level
         elapsed = poll.now_ms - lockout_start;
         if (elapsed > TimeWidth'(cfg_lockout_ms)) begin
            lamp_mode = seen_level ? MODE_BRIGHT : MODE_DARK;
            return 1'b1;
         end
         return 1'b0;
      end
      if (poll.level == seen_level)
         return 1'b0;
      lamp_mode     = MODE_DEBOUNCE;
      seen_level    = poll.level;
      lockout_start = poll.now_ms;
      if (poll.level) begin
         state_byte = STATE_BYTE_LIT;
         code_byte  = cfg_leave;
      end else begin
         // count bumps before the frame is built, so the frame carries it
         dark_entries = dark_entries + 1'b1;
         state_byte   = STATE_BYTE_UNLIT;
         code_byte    = cfg_enter;
      end
      frame_bytes = '{FRAME_START, FRAME_VERSION, cfg_device, cfg_port, FRAME_KIND,
                      state_byte, code_byte, dark_entries[7:0], dark_entries[15:8],
                      FRAME_STOP};
      for (int i = 0; i < FrameLen; i++) begin
         entry.frame_byte = frame_bytes[i];
         entry.frame_end  = (i == FrameLen - 1);
         frames_due.push_back(entry);
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Gap length: mostly none or short, now and then long.
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // Frame byte checker: compare every accepted byte with the oldest
   // expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : frame_byte_check
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_checked++;
         if (rsp_data.frame_end)
            frames_checked++;
         if (frames_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected frame byte %02h (end %0b), nothing expected",
                     $time, rsp_data.frame_byte, rsp_data.frame_end);
         end else begin
            due = frames_due.pop_front();
            if (rsp_data.frame_byte !== due.frame_byte) begin
               mismatch_count++;
               $display("%0t: frame_byte expected %02h actual %02h",
                        $time, due.frame_byte, rsp_data.frame_byte);
            end
            if (rsp_data.frame_end !== due.frame_end) begin
               mismatch_count++;
               $display("%0t: frame_end expected %0b actual %0b",
                        $time, due.frame_end, rsp_data.frame_end);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random back-pressure on the frame byte channel; with idling
   // off, always ready.
   // ------------------------------------------------------------------
   initial begin : byte_sink
      int hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) < 3) begin
            hold = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender: present one poll, hold it until accepted, then predict and
   // maybe idle. Valid stays high into the next call when there is no gap.
   // ------------------------------------------------------------------
   task automatic send_poll(input logic [TimeWidth-1:0] t, input logic lvl,
                            output bit mattered);
      req_type poll;
      int      gap;
      poll.now_ms = t;
      poll.level  = lvl;
      req_valid <= 1'b1;
      req_data  <= poll;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      polls_sent++;
      mattered = track_poll(poll);
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic poll_at(input logic [TimeWidth-1:0] t, input logic lvl);
      bit mattered;
      send_poll(t, lvl, mattered);
   endtask

   // Drop valid and hold until every owed byte is back.
   task automatic wait_for_frames();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_due.size() != 0) @(posedge clock);
   endtask

   // Idle the block fully: no bytes owed and the front end drained.
   task automatic quiesce();
      wait_for_frames();
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Register write; the enable stays up for back-to-back writes.
   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_DEBOUNCE_MS: cfg_lockout_ms = data;
         CSR_DEVICE_CODE: cfg_device     = data[7:0];
         CSR_PORT_NUMBER: cfg_port       = data[7:0];
         CSR_ENTER_CODE:  cfg_enter      = data[7:0];
         CSR_LEAVE_CODE:  cfg_leave      = data[7:0];
         default: ;
      endcase
   endtask

   // Write all five registers, then drop the enable. Bits above an 8-bit
   // register's width go out as given and must be dropped by the block.
   task automatic write_settings(input logic [CsrDataWidth-1:0] lockout,
                                 input logic [CsrDataWidth-1:0] device,
                                 input logic [CsrDataWidth-1:0] port,
                                 input logic [CsrDataWidth-1:0] enter,
                                 input logic [CsrDataWidth-1:0] leave);
      csr_write(CSR_DEBOUNCE_MS, lockout);
      csr_write(CSR_DEVICE_CODE, device);
      csr_write(CSR_PORT_NUMBER, port);
      csr_write(CSR_ENTER_CODE, enter);
      csr_write(CSR_LEAVE_CODE, leave);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Reset values in the frame; elapsed equal to the lockout holds, one
   // more ms releases; the releasing poll ignores its level.
   task automatic test_reset_defaults();
      poll_at(32'd0, 1'b1);      // same level as reset: nothing
      poll_at(32'd5, 1'b0);      // dark entry, count 1, enter code 0
      poll_at(32'd205, 1'b1);    // elapsed 200: still locked
      poll_at(32'd206, 1'b1);    // elapsed 201: release, level not sampled
      poll_at(32'd207, 1'b1);    // bright frame, leave code 1
      poll_at(32'd408, 1'b0);    // release
      poll_at(32'd409, 1'b1);    // no change
   endtask

   // Zero lockout: a poll at the same ms stays locked, the next ms releases.
   task automatic test_zero_lockout();
      quiesce();
      write_settings(16'd0, 16'd12, 16'd0, 16'd0, 16'd1);
      poll_at(32'd1000, 1'b0);
      poll_at(32'd1000, 1'b1);
      poll_at(32'd1001, 1'b1);
      poll_at(32'd1001, 1'b1);
   endtask

   // Elapsed time across the 32-bit wrap, with all-ones and zero times.
   task automatic test_time_wrap();
      quiesce();
      write_settings(16'd10, 16'h005A, 16'h0003, 16'h0021, 16'h0042);
      poll_at(32'hFFFF_FFF0, 1'b1);   // huge elapsed: release
      poll_at(32'hFFFF_FFFA, 1'b0);   // dark frame
      poll_at(32'h0000_0004, 1'b1);   // elapsed 10 through the wrap: hold
      poll_at(32'h0000_0005, 1'b1);   // elapsed 11: release
      poll_at(32'hFFFF_FFFF, 1'b1);   // bright frame
      poll_at(32'h0000_0000, 1'b0);   // elapsed 1: hold
   endtask

   // All registers at their maximum, unused indexes written, then all zero.
   task automatic test_register_extremes();
      quiesce();
      for (int i = CSR_FIRST_UNUSED; i < (1 << CsrIdxWidth); i++)
         csr_write(CsrIdxWidth'(i), CsrDataWidth'($urandom()));
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      poll_at(32'h0000_FFFF, 1'b1);   // elapsed 65536: release
      poll_at(32'h0001_0000, 1'b0);   // dark frame, device, port and code 0xFF
      poll_at(32'h0001_FFFF, 1'b1);   // elapsed 65535: hold
      poll_at(32'h0002_0000, 1'b1);   // release
      poll_at(32'h0002_0001, 1'b1);   // bright frame
      quiesce();
      // zero data with junk in the upper byte of the 8-bit registers
      write_settings(16'h0000, 16'hAB00, 16'hCD00, 16'hEF00, 16'h5500);
      poll_at(32'h0002_0001, 1'b0);   // elapsed 0: hold
      poll_at(32'h0002_0002, 1'b0);   // release
      poll_at(32'h0002_0003, 1'b0);   // dark frame with zero header
   endtask

   // ------------------------------------------------------------------
   // Random polls: mostly level toggles spaced so lockouts end soon, with
   // hits on the lockout boundary, repeats of the current level and jumps
   // to arbitrary times. Counts only polls that did something.
   // ------------------------------------------------------------------
   task automatic random_polls(input int target);
      int   done;
      int   r;
      logic lvl;
      bit   mattered;
      done = 0;
      while (done < target) begin
         r = $urandom_range(0, 99);
         if (lamp_mode == MODE_DEBOUNCE && r < 30)
            poll_ms = lockout_start + TimeWidth'(cfg_lockout_ms) + $urandom_range(0, 1);
         else if (r < 85)
            poll_ms = poll_ms + $urandom_range(0, int'(cfg_lockout_ms) / 8 + 2);
         else if (r < 95)
            poll_ms = poll_ms + $urandom_range(0, 4 * int'(cfg_lockout_ms) + 4);
         else
            poll_ms = $urandom();
         lvl = ($urandom_range(0, 4) == 0) ? seen_level : ~seen_level;
         send_poll(poll_ms, lvl, mattered);
         if (mattered)
            done++;
         // hold off now and then until the block has caught up
         if ($urandom_range(0, 49) == 0)
            wait_for_frames();
      end
   endtask

   // Several settings in turn: short, zero (no idling), long and maximum
   // lockouts, each with random header bytes.
   task automatic test_random_mix();
      logic [CsrDataWidth-1:0] lockouts [4];
      int                      counts [4];
      lockouts = '{CsrDataWidth'($urandom_range(1, 40)), 16'd0,
                   CsrDataWidth'($urandom_range(100, 3000)), 16'hFFFF};
      counts   = '{50, 25, 30, 20};
      poll_ms  = $urandom();
      for (int p = 0; p < 4; p++) begin
         quiesce();
         idle_on = (p != 1);
         write_settings(lockouts[p], CsrDataWidth'($urandom()), CsrDataWidth'($urandom()),
                        CsrDataWidth'($urandom()), CsrDataWidth'($urandom()));
         random_polls(counts[p]);
         random_phases++;
      end
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_DEBOUNCE_MS;
      csr_wdata <= '0;
      cycle_count    = 0;
      polls_sent     = 0;
      bytes_checked  = 0;
      frames_checked = 0;
      mismatch_count = 0;
      random_phases  = 0;
      idle_on        = 1'b1;
      poll_ms        = '0;

      // shadow starts from the reset values
      cfg_lockout_ms = RST_DEBOUNCE_MS;
      cfg_device     = RST_DEVICE_CODE;
      cfg_port       = RST_PORT_NUMBER;
      cfg_enter      = RST_ENTER_CODE;
      cfg_leave      = RST_LEAVE_CODE;
      lamp_mode      = MODE_BRIGHT;
      seen_level     = 1'b1;
      lockout_start  = '0;
      dark_entries   = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_zero_lockout();
      test_time_wrap();
      test_register_extremes();
      test_random_mix();

      quiesce();
      repeat (SettleCycles) @(posedge clock);

      $display("Run covered %0d polls and %0d frames (%0d bytes) across %0d random settings",
               polls_sent, frames_checked, bytes_checked, random_phases);
      $display("plus reset values, zero and maximum lockouts, time wrap and register extremes");
      if (mismatch_count == 0 && frames_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
